// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the block checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define OSMS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("osms assertion failed");

// Next-cycle implication, disabled while reset is high.
`define OSMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("osms assertion failed");

`endif

// File: rtl/osms_pkg.sv
// ---------------------------------------------------------------------------
// osms_pkg
// Types, codes and drive helpers for the obstacle scan motor sequencer.
// ---------------------------------------------------------------------------
package osms_pkg;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 56;
   localparam int CSR_DATA_W = 12;

   typedef enum logic [3:0] {
      CMD_SCAN             = 4'd0,
      CMD_FORWARD          = 4'd1,
      CMD_BACKWARD         = 4'd2,
      CMD_BRAKE            = 4'd3,
      CMD_SOFT_LEFT_FWD    = 4'd4,
      CMD_SOFT_RIGHT_FWD   = 4'd5,
      CMD_SOFT_LEFT_BACK   = 4'd6,
      CMD_SOFT_RIGHT_BACK  = 4'd7,
      CMD_PIVOT_LEFT_FWD   = 4'd8,
      CMD_PIVOT_RIGHT_FWD  = 4'd9,
      CMD_PIVOT_LEFT_BACK  = 4'd10,
      CMD_PIVOT_RIGHT_BACK = 4'd11
   } cmd_type;

   typedef enum logic [1:0] {
      ACT_NONE = 2'd0,
      ACT_FWD  = 2'd1,
      ACT_BACK = 2'd2,
      ACT_STOP = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      CSR_FULL_SPEED     = 2'd0,
      CSR_SLOW_SPEED     = 2'd1,
      CSR_STEP_LIMIT     = 2'd2,
      CSR_CLEAR_DISTANCE = 2'd3
   } csr_index_type;

   typedef logic [1:0] motor_idx_type;

   localparam motor_idx_type M1 = 2'd0;
   localparam motor_idx_type M2 = 2'd1;
   localparam motor_idx_type M3 = 2'd2;
   localparam motor_idx_type M4 = 2'd3;

   typedef struct packed {
      logic [7:0]  full_speed;
      logic [7:0]  slow_speed;
      logic [7:0]  step_limit;
      logic [11:0] clear_distance;
   } cfg_type;

   typedef struct packed {
      logic [11:0] measured_distance;
      logic [7:0]  speed_request;
      logic [3:0]  command;
   } item_type;

   typedef struct packed {
      logic [7:0]  straight_speed;
      logic        dir_first;
      logic        dir_second;
      logic        armed;
      logic [7:0]  right_steps;
      logic [7:0]  left_steps;
      logic [7:0]  sweep_steps;
      logic [7:0]  reverse_steps;
      logic        right_valid;
      logic [11:0] right_reading;
      logic        left_valid;
      logic [11:0] left_reading;
   } state_type;

   typedef struct packed {
      logic [3:0][7:0] spd;
      logic [3:0][1:0] act;
      logic            dir_first;
      logic            dir_second;
      logic            armed;
   } motion_type;

   typedef struct packed {
      logic            scanning;
      logic [7:0]      present_speed;
      logic [3:0][7:0] spd;
      logic [3:0][1:0] act;
   } result_type;

   function automatic motion_type pair_drive(
      motion_type m, motor_idx_type a, motor_idx_type b, logic [7:0] s1, logic f1,
      motor_idx_type c, motor_idx_type d, logic [7:0] s2, logic f2);
      motion_type r;
      r = m;
      r.act[a] = f1 ? ACT_FWD : ACT_BACK;
      r.act[b] = f1 ? ACT_FWD : ACT_BACK;
      r.spd[a] = s1;
      r.spd[b] = s1;
      if (r.dir_first != f1 || r.dir_second != f2) begin
         r.dir_first  = f1;
         r.dir_second = f2;
         r.armed      = 1'b0;
      end
      if (r.armed) begin
         r.act[c] = f2 ? ACT_FWD : ACT_BACK;
         r.act[d] = f2 ? ACT_FWD : ACT_BACK;
         r.spd[c] = s2;
         r.spd[d] = s2;
      end else begin
         r.armed = 1'b1;
      end
      return r;
   endfunction

   function automatic motion_type brake_all(motion_type m);
      motion_type r;
      r = m;
      for (int i = 0; i < 4; i++) begin
         r.act[i] = ACT_STOP;
      end
      return r;
   endfunction

   function automatic motion_type pivot_left_fwd(motion_type m, logic [7:0] fs);
      return pair_drive(m, M2, M4, fs, 1'b1, M1, M3, fs, 1'b0);
   endfunction

   function automatic motion_type pivot_right_fwd(motion_type m, logic [7:0] fs);
      return pair_drive(m, M1, M3, fs, 1'b1, M2, M4, fs, 1'b0);
   endfunction

endpackage

// File: rtl/osms_step.sv
// ---------------------------------------------------------------------------
// osms_step
// Next-state and motor result logic for one command or scan step.
// ---------------------------------------------------------------------------
module osms_step import osms_pkg::*; (
   input  cfg_type    cfg,
   input  state_type  state_cur,
   input  item_type   item,
   output state_type  state_nxt,
   output result_type result
);

   always_comb begin
      motion_type  m;
      state_type   s;
      logic [7:0]  lim;
      logic [7:0]  fs;
      logic [7:0]  hs;
      logic [11:0] far;

      s   = state_cur;
      lim = cfg.step_limit;
      fs  = cfg.full_speed;
      hs  = cfg.slow_speed;
      far = '0;

      m.act        = '0;
      m.spd        = '0;
      m.dir_first  = state_cur.dir_first;
      m.dir_second = state_cur.dir_second;
      m.armed      = state_cur.armed;

      case (cmd_type'(item.command))
         CMD_SCAN: begin
            // right sweep, then sample
            if (!s.right_valid) begin
               if (s.right_steps < lim) begin
                  m = pivot_right_fwd(m, fs);
                  s.right_steps = s.right_steps + 8'd1;
               end else begin
                  s.right_valid   = 1'b1;
                  s.right_reading = item.measured_distance;
                  m = brake_all(m);
               end
            end
            // return from the right
            if (s.right_steps != 8'd0 && s.right_valid) begin
               m = pivot_left_fwd(m, fs);
               s.right_steps = s.right_steps - 8'd1;
               if (s.right_steps == 8'd0) begin
                  m = brake_all(m);
               end
            end
            // left sweep, then sample
            if (s.right_valid && s.right_steps == 8'd0 && !s.left_valid) begin
               if (s.left_steps < lim) begin
                  m = pivot_left_fwd(m, fs);
                  s.left_steps = s.left_steps + 8'd1;
               end else begin
                  s.left_valid   = 1'b1;
                  s.left_reading = item.measured_distance;
                  m = brake_all(m);
               end
            end
            // equal readings
            if (s.left_valid && s.right_valid && s.left_reading == s.right_reading &&
                s.left_steps != 8'd0) begin
               m = pivot_right_fwd(m, fs);
               s.left_steps = s.left_steps - 8'd1;
            end
            // right is farther
            if (s.left_valid && s.right_valid && s.right_reading > s.left_reading) begin
               if (s.left_steps != 8'd0) begin
                  m = pivot_right_fwd(m, fs);
                  s.left_steps = s.left_steps - 8'd1;
               end else if (s.sweep_steps < lim) begin
                  m = pivot_right_fwd(m, fs);
                  s.sweep_steps = s.sweep_steps + 8'd1;
               end
            end
            // left is farther
            if (s.left_valid && (!s.right_valid || s.right_reading < s.left_reading)) begin
               if (s.sweep_steps < lim) begin
                  s.sweep_steps = lim;
               end
            end
            // room ahead: skip reverse
            if (s.left_valid && s.sweep_steps >= lim) begin
               far = (s.right_valid && s.right_reading > s.left_reading) ?
                     s.right_reading : s.left_reading;
               if (far >= cfg.clear_distance) begin
                  s.reverse_steps = lim;
               end
            end
            // reverse
            if (s.sweep_steps >= lim && s.reverse_steps < lim) begin
               s.straight_speed = fs;
               m = pair_drive(m, M1, M2, fs, 1'b0, M3, M4, fs, 1'b0);
               s.reverse_steps = s.reverse_steps + 8'd1;
               if (s.reverse_steps >= lim) begin
                  m = brake_all(m);
               end
            end
            // done
            if (s.sweep_steps >= lim && s.reverse_steps >= lim) begin
               s.reverse_steps = '0;
               s.left_steps    = '0;
               s.right_steps   = '0;
               s.sweep_steps   = '0;
               s.left_valid    = 1'b0;
               s.right_valid   = 1'b0;
            end
         end
         CMD_FORWARD, CMD_BACKWARD: begin
            s.straight_speed = (item.speed_request == 8'd0) ? fs : item.speed_request;
            m = pair_drive(m, M1, M2, s.straight_speed, item.command == CMD_FORWARD,
                           M3, M4, s.straight_speed, item.command == CMD_FORWARD);
         end
         CMD_BRAKE:            m = brake_all(m);
         CMD_SOFT_LEFT_FWD:    m = pair_drive(m, M1, M3, hs, 1'b1, M2, M4, fs, 1'b0);
         CMD_SOFT_RIGHT_FWD:   m = pair_drive(m, M1, M3, fs, 1'b1, M2, M4, hs, 1'b0);
         CMD_SOFT_LEFT_BACK:   m = pair_drive(m, M2, M4, fs, 1'b0, M1, M3, hs, 1'b1);
         CMD_SOFT_RIGHT_BACK:  m = pair_drive(m, M1, M3, fs, 1'b0, M2, M4, hs, 1'b1);
         CMD_PIVOT_LEFT_FWD:   m = pivot_left_fwd(m, fs);
         CMD_PIVOT_RIGHT_FWD:  m = pivot_right_fwd(m, fs);
         CMD_PIVOT_LEFT_BACK:  m = pair_drive(m, M2, M4, fs, 1'b0, M1, M3, fs, 1'b1);
         CMD_PIVOT_RIGHT_BACK: m = pair_drive(m, M1, M3, fs, 1'b0, M2, M4, fs, 1'b1);
         default: ;
      endcase

      s.dir_first  = m.dir_first;
      s.dir_second = m.dir_second;
      s.armed      = m.armed;

      state_nxt            = s;
      result.act           = m.act;
      result.spd           = m.spd;
      result.present_speed = s.straight_speed;
      result.scanning      = (s.right_steps != 8'd0) || (s.left_steps != 8'd0) ||
                             (s.sweep_steps != 8'd0) || (s.reverse_steps != 8'd0);
   end

endmodule

// File: rtl/obstacle_scan_motor_sequencer.sv
// ---------------------------------------------------------------------------
// obstacle_scan_motor_sequencer
// Four-motor drive sequencer: direct motion commands and obstacle scan steps.
// Result path: the accepted item is registered (input reg), then its result (result reg).
// Throughput: one item per cycle while the result is not stalled; sequencer state
// updates as each item is processed and is registered, so the next item sees it.
// Reset (synchronous): config to defaults, scan state cleared, items dropped.
// ---------------------------------------------------------------------------
module obstacle_scan_motor_sequencer import osms_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // command, speed_request, measured_distance
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // motor_one..four_action, motor_one..four_speed,
                                              // present_speed, scanning, zero pad
   input  logic                  csr_write_enable,
   input  logic [1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type    cfg_ff;
   state_type  state_ff;
   state_type  state_in;
   item_type   item_ff;
   logic       item_valid_ff;
   result_type rsp_data_ff;
   result_type rsp_data_in;
   logic       rsp_valid_ff;
   logic       advance;

   assign advance    = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - $bits(result_type)){1'b0}}, rsp_data_ff};

   osms_step u_step (
      .cfg       (cfg_ff),
      .state_cur (state_ff),
      .item      (item_ff),
      .state_nxt (state_in),
      .result    (rsp_data_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         cfg_ff.full_speed     <= 8'd255;
         cfg_ff.slow_speed     <= 8'd128;
         cfg_ff.step_limit     <= 8'd10;
         cfg_ff.clear_distance <= 12'd30;
         state_ff <= '{straight_speed: 8'd255, dir_first: 1'b1, dir_second: 1'b1,
                       default: '0};
      end else begin
         if (req_tready) begin
            item_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_FULL_SPEED:     cfg_ff.full_speed     <= csr_wdata[7:0];
               CSR_SLOW_SPEED:     cfg_ff.slow_speed     <= csr_wdata[7:0];
               CSR_STEP_LIMIT:     cfg_ff.step_limit     <= csr_wdata[7:0];
               CSR_CLEAR_DISTANCE: cfg_ff.clear_distance <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= req_tdata;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// File: rtl/osms_checker.sv
// ---------------------------------------------------------------------------
// osms_checker
// Port-level checks for the obstacle scan motor sequencer.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module osms_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [23:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic        csr_write_enable,
   input logic [1:0]  csr_index,
   input logic [11:0] csr_wdata
);

   `OSMS_ASSERT_IMPL(a_no_rsp_after_reset, clock, reset, $past(reset), !rsp_tvalid)

   `OSMS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                     rsp_tvalid && $stable(rsp_tdata))

   `OSMS_ASSERT_IMPL(a_pad_zero, clock, reset, rsp_tvalid, rsp_tdata[55:49] == 7'd0)

   `OSMS_ASSERT_IMPL(a_idle_motor_no_speed, clock, reset,
                     rsp_tvalid && rsp_tdata[1:0] == 2'd0, rsp_tdata[15:8] == 8'd0)

   // input only backs up behind a stalled result
   `OSMS_ASSERT_IMPL(a_ready_only_stalled_by_rsp, clock, reset, !req_tready,
                     rsp_tvalid && !rsp_tready)

endmodule

bind obstacle_scan_motor_sequencer osms_checker u_osms_checker (.*);
